### src/dpdd_pkg.sv
package dpdd_pkg;

	localparam int INTEGRAL_WIDTH_DEF = 32;
	localparam int INTEGRAL_WIDTH_MAX = 48;
	localparam int SPLIT_W = INTEGRAL_WIDTH_MAX / 2;
	localparam int IEXT_W = 2 * SPLIT_W;

	localparam int GAIN_W = 16;
	localparam int RADIUS_W = 12;
	localparam int LIMIT_W = 10;
	localparam int CFG_DATA_W = 16;
	localparam int DELTA_W = 16;
	localparam int YAW_W = 16;
	localparam int TS_W = 24;
	localparam int TR_W = 16;
	localparam int DUTY_W = 11;

	localparam int LSUM_W = DELTA_W + 1;
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int MUL_B_W = 26;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int MEAS_W = 24;
	localparam int MEAS_SHIFT = 5;
	localparam int ERR_S_W = TS_W + 1;
	localparam int ERR_R_W = TR_W + 1;
	localparam int D_S_W = ERR_S_W + 1;
	localparam int D_R_W = ERR_R_W + 1;
	localparam int OUT_SHIFT = 8;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_KP_S   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KI_S   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KD_S   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KP_R   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KI_R   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_KD_R   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd7;

	localparam logic [GAIN_W-1:0] KP_S_RESET = 16'd768;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd0;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd96;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd950;

	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NONE = 3'd0;
	localparam logic [OP_W-1:0] OP_MEAS = 3'd1;
	localparam logic [OP_W-1:0] OP_ERR  = 3'd2;
	localparam logic [OP_W-1:0] OP_UPD  = 3'd3;
	localparam logic [OP_W-1:0] OP_MAC  = 3'd4;
	localparam logic [OP_W-1:0] OP_SUM  = 3'd5;

	localparam int SEL_W = 3;
	localparam logic [1:0] TERM_P   = 2'd0;
	localparam logic [1:0] TERM_D   = 2'd1;
	localparam logic [1:0] TERM_ILO = 2'd2;
	localparam logic [1:0] TERM_IHI = 2'd3;
	localparam int MAC_STEPS = 8;

	typedef struct packed {
		logic             load_in;
		logic [OP_W-1:0]  op;
		logic [SEL_W-1:0] sel;
		logic             load_out;
	} cmd_t;

endpackage

### src/dual_pid_differential_drive.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// in       | in_valid / in_ready  | wheel deltas, yaw rate, straight/rotate target
// out      | out_valid / out_ready| duty_right, duty_left, clip flags
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// items are processed one at a time, in order: measure, error, state update,
// eight passes through the shared 17x26 multiplier, drain, sum and clamp. the
// next item is taken once the previous one is in the output register. reset
// loads the register defaults and clears integrals and previous errors. a
// result not yet taken holds back only the final clamp.
module dual_pid_differential_drive #(
	parameter int INTEGRAL_WIDTH = dpdd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [dpdd_pkg::DELTA_W-1:0]     left_angle_delta,
	input  logic signed [dpdd_pkg::DELTA_W-1:0]     right_angle_delta,
	input  logic signed [dpdd_pkg::YAW_W-1:0]       yaw_rate,
	input  logic signed [dpdd_pkg::TS_W-1:0]        target_straight,
	input  logic signed [dpdd_pkg::TR_W-1:0]        target_rotate,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [dpdd_pkg::DUTY_W-1:0]      duty_right,
	output logic signed [dpdd_pkg::DUTY_W-1:0]      duty_left,
	output logic                                    right_clipped,
	output logic                                    left_clipped,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [dpdd_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import dpdd_pkg::*;

	cmd_t cmd;

	assign cfg_ready = 1'b1;

	dpdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dpdd_dp #(
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.left_angle_delta  (left_angle_delta),
		.right_angle_delta (right_angle_delta),
		.yaw_rate          (yaw_rate),
		.target_straight   (target_straight),
		.target_rotate     (target_rotate),
		.duty_right        (duty_right),
		.duty_left         (duty_left),
		.right_clipped     (right_clipped),
		.left_clipped      (left_clipped)
	);

endmodule

### src/dpdd_ctrl.sv
module dpdd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output dpdd_pkg::cmd_t   cmd
);
	import dpdd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MEAS  = 3'd1;
	localparam logic [2:0] S_ERR   = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_MAC   = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_SUM   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [SEL_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             fin_go;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign fin_go = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_MEAS;
				end
			end
			S_MEAS: begin
				cmd.op = OP_MEAS;
				state_d = S_ERR;
			end
			S_ERR: begin
				cmd.op = OP_ERR;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.op = OP_UPD;
				state_d = S_MAC;
			end
			S_MAC: begin
				cmd.op = OP_MAC;
				cmd.sel = cnt_q;
				if (cnt_q == SEL_W'(MAC_STEPS - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.op = OP_SUM;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.load_out = fin_go;
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MAC) begin
				cnt_q <= cnt_q + SEL_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/dpdd_dp.sv
module dpdd_dp #(
	parameter int INTEGRAL_WIDTH = dpdd_pkg::INTEGRAL_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  dpdd_pkg::cmd_t                          cmd,
	input  logic                                    cfg_we,
	input  logic [dpdd_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [dpdd_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [dpdd_pkg::DELTA_W-1:0]     left_angle_delta,
	input  logic signed [dpdd_pkg::DELTA_W-1:0]     right_angle_delta,
	input  logic signed [dpdd_pkg::YAW_W-1:0]       yaw_rate,
	input  logic signed [dpdd_pkg::TS_W-1:0]        target_straight,
	input  logic signed [dpdd_pkg::TR_W-1:0]        target_rotate,
	output logic signed [dpdd_pkg::DUTY_W-1:0]      duty_right,
	output logic signed [dpdd_pkg::DUTY_W-1:0]      duty_left,
	output logic                                    right_clipped,
	output logic                                    left_clipped
);
	import dpdd_pkg::*;

	localparam int IW = INTEGRAL_WIDTH;
	localparam int SUM_W = ((IW > ERR_S_W) ? IW : ERR_S_W) + 1;
	localparam int AW = ((IW + GAIN_W > D_S_W + GAIN_W) ? IW + GAIN_W : D_S_W + GAIN_W) + 2;
	localparam int RW = AW - OUT_SHIFT + 1;
	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W - IW + 1){1'b0}}, {(IW - 1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [GAIN_W-1:0]   kp_s_q, ki_s_q, kd_s_q, kp_r_q, ki_r_q, kd_r_q;
	logic [RADIUS_W-1:0]        radius_q;
	logic [LIMIT_W-1:0]         limit_q;

	logic signed [DELTA_W-1:0]  left_q, right_q;
	logic signed [YAW_W-1:0]    yaw_q;
	logic signed [TS_W-1:0]     ts_q;
	logic signed [TR_W-1:0]     tr_q;

	logic signed [ERR_S_W-1:0]  err_s_q, prev_s_q;
	logic signed [ERR_R_W-1:0]  err_r_q, prev_r_q;
	logic signed [D_S_W-1:0]    d_s_q;
	logic signed [D_R_W-1:0]    d_r_q;
	logic signed [IW-1:0]       integ_s_q, integ_r_q;

	logic signed [PROD_W-1:0]   prod_q;
	logic                       pv_q;
	logic                       tag_rot_q;
	logic                       tag_hi_q;
	logic signed [AW-1:0]       acc_s_q, acc_r_q;
	logic signed [RW-1:0]       raw_r_q, raw_l_q;

	logic signed [DUTY_W-1:0]   duty_right_q, duty_left_q;
	logic                       right_clip_q, left_clip_q;

	logic signed [LSUM_W-1:0]   lsum;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [GAIN_W-1:0]   gain_p, gain_i, gain_d;
	logic signed [IW-1:0]       integ_sel;
	logic signed [IEXT_W-1:0]   integ_ext;
	logic signed [MUL_B_W-1:0]  op_lo, op_hi, op_err, op_d;
	logic signed [MEAS_W-1:0]   meas;
	logic signed [SUM_W-1:0]    isum_s, isum_r;
	logic signed [IW-1:0]       isat_s, isat_r;
	logic signed [AW-1:0]       term;
	logic signed [AW-1:0]       acc_s_sh, acc_r_sh;
	logic signed [RW-1:0]       so, ro;
	logic signed [RW-1:0]       lim_ext;
	logic signed [DUTY_W-1:0]   lim_pos, lim_neg;
	logic signed [DUTY_W-1:0]   dr_n, dl_n;
	logic                       cr_n, cl_n;

	function automatic logic signed [IW-1:0] sat_int(input logic signed [SUM_W-1:0] x);
		logic signed [IW-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[IW-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[IW-1:0];
		end else begin
			r = x[IW-1:0];
		end
		return r;
	endfunction

	assign lsum = LSUM_W'(left_q) + LSUM_W'(right_q);

	always_comb begin
		if (cmd.sel[2]) begin
			gain_p = kp_r_q;
			gain_i = ki_r_q;
			gain_d = kd_r_q;
			integ_sel = integ_r_q;
			op_err = MUL_B_W'(err_r_q);
			op_d = MUL_B_W'(d_r_q);
		end else begin
			gain_p = kp_s_q;
			gain_i = ki_s_q;
			gain_d = kd_s_q;
			integ_sel = integ_s_q;
			op_err = MUL_B_W'(err_s_q);
			op_d = MUL_B_W'(d_s_q);
		end
		integ_ext = IEXT_W'(integ_sel);
		op_lo = $signed({{(MUL_B_W - SPLIT_W){1'b0}}, integ_ext[SPLIT_W-1:0]});
		op_hi = MUL_B_W'($signed(integ_ext[IEXT_W-1:SPLIT_W]));
		if (cmd.op == OP_MEAS) begin
			mul_a = $signed({{(MUL_A_W - RADIUS_W){1'b0}}, radius_q});
			mul_b = MUL_B_W'(lsum);
		end else begin
			case (cmd.sel[1:0])
				TERM_P: begin
					mul_a = MUL_A_W'(gain_p);
					mul_b = op_err;
				end
				TERM_D: begin
					mul_a = MUL_A_W'(gain_d);
					mul_b = op_d;
				end
				TERM_ILO: begin
					mul_a = MUL_A_W'(gain_i);
					mul_b = op_lo;
				end
				default: begin
					mul_a = MUL_A_W'(gain_i);
					mul_b = op_hi;
				end
			endcase
		end
	end

	assign prod = mul_a * mul_b;

	assign meas = $signed(prod_q[MEAS_SHIFT +: MEAS_W]);
	assign isum_s = SUM_W'(integ_s_q) + SUM_W'(err_s_q);
	assign isum_r = SUM_W'(integ_r_q) + SUM_W'(err_r_q);
	assign isat_s = sat_int(isum_s);
	assign isat_r = sat_int(isum_r);

	always_comb begin
		term = AW'(prod_q);
		if (tag_hi_q) begin
			term = term <<< SPLIT_W;
		end
	end

	assign acc_s_sh = acc_s_q >>> OUT_SHIFT;
	assign acc_r_sh = acc_r_q >>> OUT_SHIFT;
	assign so = acc_s_sh[RW-1:0];
	assign ro = acc_r_sh[RW-1:0];

	// symmetric clamp against the duty limit
	assign lim_ext = $signed({{(RW - LIMIT_W){1'b0}}, limit_q});
	assign lim_pos = $signed({{(DUTY_W - LIMIT_W){1'b0}}, limit_q});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (raw_r_q > lim_ext) begin
			dr_n = lim_pos;
			cr_n = 1'b1;
		end else if (raw_r_q < -lim_ext) begin
			dr_n = lim_neg;
			cr_n = 1'b1;
		end else begin
			dr_n = raw_r_q[DUTY_W-1:0];
			cr_n = 1'b0;
		end
		if (raw_l_q > lim_ext) begin
			dl_n = lim_pos;
			cl_n = 1'b1;
		end else if (raw_l_q < -lim_ext) begin
			dl_n = lim_neg;
			cl_n = 1'b1;
		end else begin
			dl_n = raw_l_q[DUTY_W-1:0];
			cl_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_s_q <= KP_S_RESET;
			ki_s_q <= GAIN_RESET;
			kd_s_q <= GAIN_RESET;
			kp_r_q <= GAIN_RESET;
			ki_r_q <= GAIN_RESET;
			kd_r_q <= GAIN_RESET;
			radius_q <= RADIUS_RESET;
			limit_q <= LIMIT_RESET;
			integ_s_q <= '0;
			integ_r_q <= '0;
			prev_s_q <= '0;
			prev_r_q <= '0;
			pv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KP_S:   kp_s_q <= cfg_data;
					REG_KI_S:   ki_s_q <= cfg_data;
					REG_KD_S:   kd_s_q <= cfg_data;
					REG_KP_R:   kp_r_q <= cfg_data;
					REG_KI_R:   ki_r_q <= cfg_data;
					REG_KD_R:   kd_r_q <= cfg_data;
					REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
					REG_LIMIT:  limit_q <= cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_UPD) begin
				integ_s_q <= isat_s;
				integ_r_q <= isat_r;
				prev_s_q <= err_s_q;
				prev_r_q <= err_r_q;
			end
			pv_q <= (cmd.op == OP_MAC);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			left_q <= left_angle_delta;
			right_q <= right_angle_delta;
			yaw_q <= yaw_rate;
			ts_q <= target_straight;
			tr_q <= target_rotate;
		end
		if (cmd.op == OP_MEAS || cmd.op == OP_MAC) begin
			prod_q <= prod;
			tag_rot_q <= cmd.sel[2];
			tag_hi_q <= (cmd.op == OP_MAC) && (cmd.sel[1:0] == TERM_IHI);
		end
		if (cmd.op == OP_ERR) begin
			err_s_q <= ERR_S_W'(ts_q) - ERR_S_W'(meas);
			err_r_q <= ERR_R_W'(tr_q) - ERR_R_W'(yaw_q);
		end
		if (cmd.op == OP_UPD) begin
			d_s_q <= D_S_W'(err_s_q) - D_S_W'(prev_s_q);
			d_r_q <= D_R_W'(err_r_q) - D_R_W'(prev_r_q);
			acc_s_q <= '0;
			acc_r_q <= '0;
		end else if (pv_q) begin
			if (tag_rot_q) begin
				acc_r_q <= acc_r_q + term;
			end else begin
				acc_s_q <= acc_s_q + term;
			end
		end
		if (cmd.op == OP_SUM) begin
			raw_r_q <= so + ro;
			raw_l_q <= so - ro;
		end
		if (cmd.load_out) begin
			duty_right_q <= dr_n;
			duty_left_q <= dl_n;
			right_clip_q <= cr_n;
			left_clip_q <= cl_n;
		end
	end

	assign duty_right = duty_right_q;
	assign duty_left = duty_left_q;
	assign right_clipped = right_clip_q;
	assign left_clipped = left_clip_q;

endmodule
